// File: rtl/ptpw_pkg.sv
`default_nettype none

package ptpw_pkg;

   localparam int TABLE_SLOTS_DEF    = 64;
   localparam int STACK_DEPTH_DEF    = 8;
   localparam int MAX_NEW_TABLES_DEF = 15;

   localparam int ENTRIES_PER_TABLE = 512;
   localparam int IDX_W             = 9;
   localparam int FRAME_W           = 40;
   localparam int PA_W              = 52;
   localparam int VA_W              = 48;
   localparam int PAGE_W            = 12;

   // present, writable, user
   localparam logic [PAGE_W-1:0] ENTRY_FLAGS = 12'h007;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_SLOTS = 2'd1,
      STAT_STACK = 2'd2,
      STAT_LIMIT = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_CLR_ROOT,
      S_IDLE,
      S_START,
      S_RD,
      S_CHK,
      S_EMIT_LEAF,
      S_EMIT_ALLOC,
      S_CLR_SLOT,
      S_RESUME,
      S_FIN_HELD,
      S_FIN_LAST
   } state_type;

   typedef struct packed {
      logic       load_item;
      logic       walk_start;
      logic       mem_read;
      logic       walk_step;
      logic       level_up;
      logic       write_leaf;
      logic       alloc;
      logic       clr_write;
      logic       pop;
      logic       set_status;
      status_type status_code;
      logic       emit;
      logic       send_held;
      logic       send_last;
   } dp_cmd_type;

   typedef struct packed {
      logic below;
      logic slot_bad;
      logic present;
      logic at_leaf;
      logic lim_hit;
      logic slots_full;
      logic stack_full;
      logic sp_zero;
      logic held_valid;
      logic out_free;
      logic clr_done;
      logic status_ok;
   } dp_stat_type;

endpackage

`default_nettype wire

// File: rtl/ptpw_ctrl.sv
`default_nettype none

module ptpw_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  ptpw_pkg::dp_stat_type   stat,
   output ptpw_pkg::dp_cmd_type    cmd
);
   import ptpw_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR_ROOT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_CLR_ROOT: begin
            cmd.clr_write = 1'b1;
            if (stat.clr_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_START;
            end
         end
         S_START: begin
            cmd.walk_start = 1'b1;
            state_in       = S_RD;
         end
         S_RD: begin
            cmd.mem_read = 1'b1;
            state_in     = S_CHK;
         end
         S_CHK: begin
            if (stat.below) begin
               if (stat.slot_bad) begin
                  cmd.set_status  = 1'b1;
                  cmd.status_code = STAT_SLOTS;
                  state_in        = S_FIN_HELD;
               end else begin
                  cmd.walk_step = 1'b1;
                  state_in      = S_RD;
               end
            end else if (stat.present) begin
               if (stat.at_leaf) begin
                  state_in = S_RESUME;
               end else begin
                  cmd.level_up = 1'b1;
                  state_in     = S_START;
               end
            end else if (stat.at_leaf) begin
               cmd.write_leaf = 1'b1;
               state_in       = S_EMIT_LEAF;
            end else if (stat.lim_hit) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = STAT_LIMIT;
               state_in        = S_FIN_HELD;
            end else if (stat.slots_full) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = STAT_SLOTS;
               state_in        = S_FIN_HELD;
            end else if (stat.stack_full) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = STAT_STACK;
               state_in        = S_FIN_HELD;
            end else begin
               cmd.alloc = 1'b1;
               state_in  = S_EMIT_ALLOC;
            end
         end
         S_EMIT_LEAF: begin
            if (!stat.held_valid || stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_RESUME;
            end
         end
         S_EMIT_ALLOC: begin
            if (!stat.held_valid || stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_CLR_SLOT;
            end
         end
         S_CLR_SLOT: begin
            cmd.clr_write = 1'b1;
            if (stat.clr_done) state_in = S_START;
         end
         S_RESUME: begin
            if (stat.sp_zero) begin
               state_in = S_FIN_HELD;
            end else begin
               cmd.pop  = 1'b1;
               state_in = S_START;
            end
         end
         S_FIN_HELD: begin
            if (!stat.held_valid) begin
               state_in = S_FIN_LAST;
            end else if (stat.out_free) begin
               cmd.send_held = 1'b1;
               state_in      = stat.status_ok ? S_IDLE : S_FIN_LAST;
            end
         end
         S_FIN_LAST: begin
            if (stat.out_free) begin
               cmd.send_last = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/ptpw_dp.sv
`default_nettype none

module ptpw_dp #(
   parameter int TABLE_SLOTS    = ptpw_pkg::TABLE_SLOTS_DEF,
   parameter int STACK_DEPTH    = ptpw_pkg::STACK_DEPTH_DEF,
   parameter int MAX_NEW_TABLES = ptpw_pkg::MAX_NEW_TABLES_DEF
) (
   input  wire                             clock,
   input  wire                             reset,
   input  ptpw_pkg::dp_cmd_type            cmd,
   output ptpw_pkg::dp_stat_type           stat,
   input  wire [ptpw_pkg::VA_W-1:0]        req_virtual_address,
   input  wire                             csr_valid,
   input  wire [ptpw_pkg::PA_W-1:0]        csr_table_region_base,
   input  wire                             rsp_ready,
   output logic                            rsp_valid,
   output logic                            rsp_write_valid,
   output logic [ptpw_pkg::PA_W-1:0]       rsp_entry_address,
   output logic [ptpw_pkg::PA_W-1:0]       rsp_entry_value,
   output logic [1:0]                      rsp_status,
   output logic                            rsp_is_last
);
   import ptpw_pkg::*;

   localparam int ROW_W     = $clog2(TABLE_SLOTS + 1);
   localparam int MEM_DEPTH = (TABLE_SLOTS + 1) * ENTRIES_PER_TABLE;
   localparam int MA_W      = ROW_W + IDX_W;
   localparam int SP_W      = $clog2(STACK_DEPTH + 1);
   localparam int SI_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int NT_W      = $clog2(MAX_NEW_TABLES + 1);
   localparam int ENT_W     = FRAME_W + 1;
   localparam int STK_W     = FRAME_W + 2;

   // row 0 is the root table, row s+1 holds slot s
   logic [ENT_W-1:0]   table_mem [MEM_DEPTH];
   logic [ENT_W-1:0]   rdata_ff;

   logic [FRAME_W-1:0] base_ff;
   logic [FRAME_W-1:0] addr_ff;
   logic [1:0]         level_ff;
   logic [1:0]         walk_l_ff;
   logic [ROW_W-1:0]   row_ff;
   logic [FRAME_W-1:0] tframe_ff;
   logic [NT_W-1:0]    nt_ff;
   logic [ROW_W-1:0]   nf_ff;
   logic [SP_W-1:0]    sp_ff;
   logic [STK_W-1:0]   stack_ff [STACK_DEPTH];
   logic               held_valid_ff;
   logic [PA_W-1:0]    held_addr_ff;
   logic [PA_W-1:0]    held_val_ff;
   logic [PA_W-1:0]    cand_addr_ff;
   logic [PA_W-1:0]    cand_val_ff;
   status_type         status_ff;
   logic [IDX_W-1:0]   cnt_ff;
   logic [ROW_W-1:0]   clr_row_ff;

   logic               rsp_valid_ff;
   logic               rsp_wv_ff;
   logic [PA_W-1:0]    rsp_addr_ff;
   logic [PA_W-1:0]    rsp_val_ff;
   logic [1:0]         rsp_status_ff;
   logic               rsp_last_ff;

   logic [IDX_W-1:0]   idx;
   logic [FRAME_W-1:0] rd_frame;
   logic [FRAME_W-1:0] diff;
   logic [FRAME_W-1:0] new_frame;
   logic [PA_W-1:0]    ent_addr;
   logic               mem_we;
   logic [MA_W-1:0]    mem_waddr;
   logic [ENT_W-1:0]   mem_wdata;
   logic [SI_W-1:0]    pop_idx;
   logic [STK_W-1:0]   pop_ent;
   logic               out_load;
   logic               out_wv;
   logic [PA_W-1:0]    out_addr;
   logic [PA_W-1:0]    out_val;
   logic [1:0]         out_status;
   logic               out_last;

   always_comb begin
      case (walk_l_ff)
         2'd0:    idx = addr_ff[35:27];
         2'd1:    idx = addr_ff[26:18];
         2'd2:    idx = addr_ff[17:9];
         default: idx = addr_ff[8:0];
      endcase
   end

   assign rd_frame  = rdata_ff[FRAME_W-1:0];
   assign diff      = rd_frame - base_ff;
   assign new_frame = base_ff + FRAME_W'(nf_ff);
   assign ent_addr  = {tframe_ff, idx, 3'b000};
   assign pop_idx   = SI_W'(sp_ff - 1'b1);
   assign pop_ent   = stack_ff[pop_idx];

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = {row_ff, idx};
      mem_wdata = '0;
      if (cmd.clr_write) begin
         mem_we    = 1'b1;
         mem_waddr = {clr_row_ff, cnt_ff};
      end else if (cmd.write_leaf) begin
         mem_we    = 1'b1;
         mem_wdata = {1'b1, addr_ff};
      end else if (cmd.alloc) begin
         mem_we    = 1'b1;
         mem_wdata = {1'b1, new_frame};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) table_mem[mem_waddr] <= mem_wdata;
      if (cmd.mem_read) rdata_ff <= table_mem[{row_ff, idx}];
   end

   always_comb begin
      stat.below      = (walk_l_ff != level_ff);
      stat.slot_bad   = (diff >= FRAME_W'(nf_ff));
      stat.present    = rdata_ff[FRAME_W];
      stat.at_leaf    = (level_ff == 2'd3);
      stat.lim_hit    = (nt_ff >= NT_W'(MAX_NEW_TABLES));
      stat.slots_full = (nf_ff >= ROW_W'(TABLE_SLOTS));
      stat.stack_full = (sp_ff >= SP_W'(STACK_DEPTH));
      stat.sp_zero    = (sp_ff == '0);
      stat.held_valid = held_valid_ff;
      stat.out_free   = !rsp_valid_ff || rsp_ready;
      stat.clr_done   = (cnt_ff == '1);
      stat.status_ok  = (status_ff == STAT_OK);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff       <= '0;
         nf_ff         <= '0;
         nt_ff         <= '0;
         sp_ff         <= '0;
         held_valid_ff <= 1'b0;
         status_ff     <= STAT_OK;
         cnt_ff        <= '0;
         clr_row_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) base_ff <= csr_table_region_base[PA_W-1:PAGE_W];
         if (cmd.load_item) begin
            nt_ff         <= '0;
            sp_ff         <= '0;
            held_valid_ff <= 1'b0;
            status_ff     <= STAT_OK;
         end
         if (cmd.set_status) status_ff <= cmd.status_code;
         if (cmd.clr_write) cnt_ff <= cnt_ff + 1'b1;
         if (cmd.alloc) begin
            nf_ff      <= nf_ff + 1'b1;
            nt_ff      <= nt_ff + 1'b1;
            sp_ff      <= sp_ff + 1'b1;
            clr_row_ff <= ROW_W'(nf_ff + 1'b1);
            cnt_ff     <= '0;
         end
         if (cmd.pop) sp_ff <= sp_ff - 1'b1;
         if (cmd.emit) held_valid_ff <= 1'b1;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // walk payload
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         addr_ff  <= FRAME_W'(req_virtual_address[VA_W-1:PAGE_W]);
         level_ff <= 2'd0;
      end
      if (cmd.walk_start) begin
         walk_l_ff <= 2'd0;
         row_ff    <= '0;
         tframe_ff <= '0;
      end
      if (cmd.walk_step) begin
         walk_l_ff <= walk_l_ff + 1'b1;
         row_ff    <= ROW_W'(diff[ROW_W-1:0] + 1'b1);
         tframe_ff <= rd_frame;
      end
      if (cmd.level_up) level_ff <= level_ff + 1'b1;
      if (cmd.write_leaf) begin
         cand_addr_ff <= ent_addr;
         cand_val_ff  <= {addr_ff, ENTRY_FLAGS};
      end
      if (cmd.alloc) begin
         cand_addr_ff                <= ent_addr;
         cand_val_ff                 <= {new_frame, ENTRY_FLAGS};
         stack_ff[sp_ff[SI_W-1:0]]   <= {level_ff, addr_ff};
         addr_ff                     <= new_frame;
         level_ff                    <= 2'd0;
      end
      if (cmd.pop) begin
         addr_ff  <= pop_ent[FRAME_W-1:0];
         level_ff <= pop_ent[STK_W-1:FRAME_W];
      end
      if (cmd.emit) begin
         held_addr_ff <= cand_addr_ff;
         held_val_ff  <= cand_val_ff;
      end
   end

   always_comb begin
      out_load   = 1'b0;
      out_wv     = 1'b1;
      out_addr   = held_addr_ff;
      out_val    = held_val_ff;
      out_status = STAT_OK;
      out_last   = 1'b0;
      if (cmd.emit && held_valid_ff) begin
         out_load = 1'b1;
      end else if (cmd.send_held) begin
         out_load = 1'b1;
         out_last = (status_ff == STAT_OK);
      end else if (cmd.send_last) begin
         out_load   = 1'b1;
         out_wv     = 1'b0;
         out_addr   = '0;
         out_val    = '0;
         out_status = status_ff;
         out_last   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_wv_ff     <= out_wv;
         rsp_addr_ff   <= out_addr;
         rsp_val_ff    <= out_val;
         rsp_status_ff <= out_status;
         rsp_last_ff   <= out_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_write_valid   = rsp_wv_ff;
   assign rsp_entry_address = rsp_addr_ff;
   assign rsp_entry_value   = rsp_val_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_is_last       = rsp_last_ff;

endmodule

`default_nettype wire

// File: rtl/page_table_populate_walker_unit.sv
`default_nettype none

// Channel   Direction  Handshake              Payload
// req       in         req_valid/req_ready    req_virtual_address[47:0]
// rsp       out        rsp_valid/rsp_ready    write_valid, entry_address, entry_value,
//                                             status, is_last
// csr       in         csr_valid/csr_ready    csr_table_region_base[51:0]
//
// One request at a time. Each table level takes a table read and then a check, and
// every level change re-walks from the root; each new table also has to be cleared
// through the single table memory write port before the walk goes on into it.
// After reset the root table is cleared first, with req_ready low.
// Results wait in a holding register and in the output register while the walk goes
// on; the walk stalls only when a new result is ready while both are still full.

module page_table_populate_walker_unit #(
   parameter int TABLE_SLOTS    = ptpw_pkg::TABLE_SLOTS_DEF,
   parameter int STACK_DEPTH    = ptpw_pkg::STACK_DEPTH_DEF,
   parameter int MAX_NEW_TABLES = ptpw_pkg::MAX_NEW_TABLES_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire [ptpw_pkg::VA_W-1:0]     req_virtual_address,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output logic                         rsp_write_valid,
   output logic [ptpw_pkg::PA_W-1:0]    rsp_entry_address,
   output logic [ptpw_pkg::PA_W-1:0]    rsp_entry_value,
   output logic [1:0]                   rsp_status,
   output logic                         rsp_is_last,
   input  wire                          csr_valid,
   output logic                         csr_ready,
   input  wire [ptpw_pkg::PA_W-1:0]     csr_table_region_base
);
   import ptpw_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // base register is writable in any cycle
   assign csr_ready = 1'b1;

   // sequence the walk: read, check, allocate, clear, resume
   ptpw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // hold the table memory, stack, allocator and the output register
   ptpw_dp #(
      .TABLE_SLOTS    (TABLE_SLOTS),
      .STACK_DEPTH    (STACK_DEPTH),
      .MAX_NEW_TABLES (MAX_NEW_TABLES)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .stat                  (stat),
      .req_virtual_address   (req_virtual_address),
      .csr_valid             (csr_valid),
      .csr_table_region_base (csr_table_region_base),
      .rsp_ready             (rsp_ready),
      .rsp_valid             (rsp_valid),
      .rsp_write_valid       (rsp_write_valid),
      .rsp_entry_address     (rsp_entry_address),
      .rsp_entry_value       (rsp_entry_value),
      .rsp_status            (rsp_status),
      .rsp_is_last           (rsp_is_last)
   );

endmodule

`default_nettype wire

// File: bench/page_table_populate_walker_unit_checker.sv
`timescale 1ns / 100ps

module page_table_populate_walker_unit_checker (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   input  wire                        req_ready,
   input  wire [ptpw_pkg::VA_W-1:0]   req_virtual_address,
   input  wire                        rsp_valid,
   input  wire                        rsp_ready,
   input  wire                        rsp_write_valid,
   input  wire [ptpw_pkg::PA_W-1:0]   rsp_entry_address,
   input  wire [ptpw_pkg::PA_W-1:0]   rsp_entry_value,
   input  wire [1:0]                  rsp_status,
   input  wire                        rsp_is_last,
   input  wire                        csr_valid,
   input  wire                        csr_ready,
   input  wire [ptpw_pkg::PA_W-1:0]   csr_table_region_base,
   output int                         pending_writes,
   output int                         fail_count
);
   import ptpw_pkg::*;

   localparam int          SLOTS      = TABLE_SLOTS_DEF;
   localparam int          STACK_MAX  = STACK_DEPTH_DEF;
   localparam int          NEW_MAX    = MAX_NEW_TABLES_DEF;
   localparam logic [63:0] FRAME_MASK = 64'h000f_ffff_ffff_f000;
   localparam logic [63:0] PA_MASK    = 64'h000f_ffff_ffff_ffff;

   typedef struct packed {
      logic        write_valid;
      logic [51:0] entry_address;
      logic [51:0] entry_value;
      logic [1:0]  status;
      logic        is_last;
   } entry_write_type;

   logic [63:0]     region_base;
   logic [63:0]     root_entries [0:ENTRIES_PER_TABLE-1];
   logic [63:0]     slot_entries [0:SLOTS*ENTRIES_PER_TABLE-1];
   int              free_slot;
   logic [63:0]     walk_stack [0:STACK_MAX-1];
   entry_write_type expected_writes [$];

   initial begin
      region_base    = '0;
      free_slot      = 0;
      fail_count     = 0;
      pending_writes = 0;
      for (int i = 0; i < ENTRIES_PER_TABLE; i++) root_entries[i] = '0;
      for (int i = 0; i < SLOTS*ENTRIES_PER_TABLE; i++) slot_entries[i] = '0;
   end

   function automatic logic [63:0] slot_addr(input int s);
      return ((region_base & FRAME_MASK) + 64'(s) * 64'h1000) & PA_MASK;
   endfunction

   // -1 when the entry points at no allocated table
   function automatic int slot_of(input logic [63:0] e);
      logic [63:0] d;
      d = (((e & FRAME_MASK) - (region_base & FRAME_MASK)) & PA_MASK) >> 12;
      if (d >= 64'(free_slot) || d >= 64'(SLOTS)) return -1;
      return int'(d);
   endfunction

   function automatic int level_idx(input logic [63:0] a, input int lvl);
      return int'((a >> (39 - 9*lvl)) & 64'h1ff);
   endfunction

   function automatic logic [63:0] read_entry(input int s, input int idx);
      if (s < 0) return root_entries[idx];
      return slot_entries[s*ENTRIES_PER_TABLE + idx];
   endfunction

   task automatic write_entry(input int s, input int idx, input logic [63:0] v);
      if (s < 0) root_entries[idx] = v;
      else slot_entries[s*ENTRIES_PER_TABLE + idx] = v;
   endtask

   // Walk the tables for one request and queue every entry write it makes.
   task automatic predict_walk(input logic [VA_W-1:0] va);
      logic [63:0]     addr, tbl_addr, ent_addr, v, taddr;
      int              level, new_tables, n, sp, s, tbl, idx, slot;
      logic [1:0]      status;
      bit              bad;
      entry_write_type res [32];
      addr       = {16'h0, va} & FRAME_MASK;
      level      = 0;
      new_tables = 0;
      n          = 0;
      sp         = 0;
      status     = STAT_OK;
      while (1) begin
         tbl      = -1;
         tbl_addr = '0;
         bad      = 0;
         for (int l = 0; l < level; l++) begin
            s = slot_of(read_entry(tbl, level_idx(addr, l)));
            if (s < 0) begin
               bad = 1;
               break;
            end
            tbl      = s;
            tbl_addr = slot_addr(s);
         end
         if (bad) begin
            status = STAT_SLOTS;
            break;
         end
         idx      = level_idx(addr, level);
         ent_addr = (tbl_addr + 64'(idx) * 8) & PA_MASK;
         if (read_entry(tbl, idx) & 64'h1) begin
            if (level < 3) begin
               level++;
               continue;
            end
         end else if (level == 3) begin
            v = (addr & FRAME_MASK) | 64'h7;
            write_entry(tbl, idx, v);
            if (n < 32) begin
               res[n] = '{1'b1, ent_addr[51:0], v[51:0], STAT_OK, 1'b0};
               n++;
            end
         end else begin
            if (new_tables >= NEW_MAX) begin
               status = STAT_LIMIT;
               break;
            end
            if (free_slot >= SLOTS) begin
               status = STAT_SLOTS;
               break;
            end
            if (sp >= STACK_MAX) begin
               status = STAT_STACK;
               break;
            end
            slot = free_slot;
            free_slot++;
            new_tables++;
            for (int i = 0; i < ENTRIES_PER_TABLE; i++)
               slot_entries[slot*ENTRIES_PER_TABLE + i] = '0;
            taddr = slot_addr(slot);
            v     = (taddr & FRAME_MASK) | 64'h7;
            write_entry(tbl, idx, v);
            if (n < 32) begin
               res[n] = '{1'b1, ent_addr[51:0], v[51:0], STAT_OK, 1'b0};
               n++;
            end
            walk_stack[sp] = (addr & FRAME_MASK) | 64'(level);
            sp++;
            addr  = taddr;
            level = 0;
            continue;
         end
         // leaf done: resume the interrupted walk, if any
         if (sp == 0) break;
         sp--;
         addr  = walk_stack[sp] & FRAME_MASK;
         level = int'(walk_stack[sp] & 64'h3);
      end
      if (status != STAT_OK || n == 0) begin
         if (n >= 32) n = 31;
         res[n] = '{1'b0, 52'h0, 52'h0, status, 1'b1};
         n++;
      end else begin
         res[n-1].is_last = 1'b1;
      end
      for (int i = 0; i < n; i++) expected_writes.push_back(res[i]);
   endtask

   always @(posedge clock) begin
      entry_write_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) region_base = {12'h0, csr_table_region_base};
         if (req_valid && req_ready) predict_walk(req_virtual_address);
         if (rsp_valid && rsp_ready) begin
            if (expected_writes.size() == 0) begin
               $error("unexpected result: address %h value %h", rsp_entry_address,
                      rsp_entry_value);
               fail_count++;
            end else begin
               want = expected_writes.pop_front();
               if (rsp_write_valid !== want.write_valid) begin
                  $error("write_valid: expected %h actual %h", want.write_valid,
                         rsp_write_valid);
                  fail_count++;
               end
               if (rsp_entry_address !== want.entry_address) begin
                  $error("entry_address: expected %h actual %h", want.entry_address,
                         rsp_entry_address);
                  fail_count++;
               end
               if (rsp_entry_value !== want.entry_value) begin
                  $error("entry_value: expected %h actual %h", want.entry_value,
                         rsp_entry_value);
                  fail_count++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %h actual %h", want.status, rsp_status);
                  fail_count++;
               end
               if (rsp_is_last !== want.is_last) begin
                  $error("is_last: expected %h actual %h", want.is_last, rsp_is_last);
                  fail_count++;
               end
            end
         end
         pending_writes = expected_writes.size();
      end
   end

endmodule

// File: bench/page_table_populate_walker_unit_test.sv
`timescale 1ns / 100ps

module page_table_populate_walker_unit_test;
   import ptpw_pkg::*;

   // Root clear plus at most 64 table clears, walks and stalls on top; this limit
   // is many times that.
   localparam int CYCLE_LIMIT = 600000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [VA_W-1:0]   req_virtual_address = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_write_valid;
   logic [PA_W-1:0]   rsp_entry_address;
   logic [PA_W-1:0]   rsp_entry_value;
   logic [1:0]        rsp_status;
   logic              rsp_is_last;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [PA_W-1:0]   csr_table_region_base = '0;

   int                pending_writes;
   int                fail_count;
   int                cycle_count = 0;
   int                accepted_requests = 0;
   logic [PA_W-1:0]   current_base = '0;
   logic [VA_W-1:0]   last_va = '0;

   page_table_populate_walker_unit dut (.*);

   page_table_populate_walker_unit_checker walk_checker (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   // Abort a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("page_table_populate_walker_unit_test: errors");
         $finish;
      end
   end

   // Result side: random stall patterns, quiet stretches, and one long
   // hold-off early on so the walker backs up and drops req_ready.
   int  rsp_hold = 0;
   int  rsp_mode = 0;
   int  rsp_mode_left = 0;
   bit  long_hold_done = 0;
   always @(posedge clock) begin
      if (!long_hold_done && accepted_requests == 30) begin
         long_hold_done <= 1;
         rsp_hold       <= 400;
         rsp_ready      <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_hold  <= rsp_hold - 1;
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_mode_left == 0) begin
            rsp_mode      <= $urandom_range(0, 2);
            rsp_mode_left <= $urandom_range(8, 80);
         end else begin
            rsp_mode_left <= rsp_mode_left - 1;
         end
         case (rsp_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 3) != 0);
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // Offer one request, hold it until taken, then drop req_valid for the given gap, if any.
   task automatic send_request(input logic [VA_W-1:0] va, input int gap);
      req_valid           <= 1'b1;
      req_virtual_address <= va;
      last_va = va;
      do @(posedge clock); while (!req_ready);
      accepted_requests++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Pause the sender until every expected write has come back.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_writes != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_base(input logic [PA_W-1:0] base);
      csr_valid             <= 1'b1;
      csr_table_region_base <= base;
      current_base = base;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Mix of fresh pages, neighbors of the last page, pages near the table
   // region, and exact repeats.
   function automatic logic [VA_W-1:0] pick_address();
      logic [VA_W-1:0] va;
      case ($urandom_range(0, 7))
         0, 1: va = VA_W'({$urandom, $urandom});
         2, 3: va = {last_va[47:21], 9'($urandom_range(0, 511)), 12'($urandom)};
         4:    va = {last_va[47:30], 18'($urandom), 12'($urandom)};
         5, 6: va = current_base[VA_W-1:0] + VA_W'({$urandom_range(0, 255), 12'h0});
         default: va = last_va;
      endcase
      return va;
   endfunction

   // Burst sender: random burst lengths with random gaps between bursts.
   task automatic random_requests(input int count);
      int burst;
      burst = 0;
      for (int i = 0; i < count; i++) begin
         if (burst == 0) burst = $urandom_range(1, 8);
         burst--;
         send_request(pick_address(), (burst == 0) ? $urandom_range(1, 30) : 0);
      end
   endtask

   logic [VA_W-1:0] directed_va [12] = '{
      48'h0000_0000_0000, 48'h0000_0000_0000, 48'h0000_0000_0fff,
      48'hffff_ffff_ffff, 48'h8000_0000_0000, 48'h0000_0000_1000,
      48'h0000_0020_0000, 48'h0000_4000_0000, 48'h0080_0000_0000,
      48'h7fff_ffff_f000, 48'haaaa_aaaa_a000, 48'h5555_5555_5000
   };

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Region at zero: cold walks, repeats that write nothing, field extremes.
      write_base('0);
      foreach (directed_va[i]) send_request(directed_va[i], i % 3);
      drain();

      // Region at the top: old pointers become foreign, allocations wrap.
      write_base(52'hf_ffff_ffff_f000);
      send_request(48'h0000_0000_0000, 0);
      send_request(48'hffff_ffff_f000, 0);
      send_request(48'hffff_ffff_e000, 2);
      send_request(48'h1234_5678_9000, 0);
      drain();

      // Random regions, random traffic.
      write_base(PA_W'({$urandom, $urandom}));
      random_requests(30);
      drain();
      write_base(PA_W'({$urandom, $urandom}) | 52'h8_0000_0000_0000);
      random_requests(30);
      drain();
      write_base('0);
      random_requests(30);
      drain();

      if (fail_count == 0) begin
         $display("page_table_populate_walker_unit_test: clean");
      end else begin
         $display("page_table_populate_walker_unit_test: errors");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/ptpw_pkg.sv
rtl/ptpw_ctrl.sv
rtl/ptpw_dp.sv
rtl/page_table_populate_walker_unit.sv
bench/page_table_populate_walker_unit_checker.sv
bench/page_table_populate_walker_unit_test.sv
